// ===== sv/htsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Huffman tree stream decoder package
// Shared types, codes and constants for the tree walking decoder.
// ----------------------------------------------------------------------------
package htsd_pkg;

    localparam int NODE_IDX_W = 9;
    localparam int NODE_COUNT = 2 ** NODE_IDX_W;
    localparam int SYM_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 32;
    localparam int BITCNT_W   = $clog2(BYTE_W + 1);

    localparam logic [0:0] ACT_LOAD   = 1'b0;
    localparam logic [0:0] ACT_DECODE = 1'b1;

    localparam logic [0:0] CFG_TOTAL_BYTES = 1'b0;
    localparam logic [0:0] CFG_ROOT_INDEX  = 1'b1;

    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_EIGHT = 8'h38;

    localparam logic [BITCNT_W-1:0] FULL_BITS = BITCNT_W'(BYTE_W);

    typedef struct packed {
        logic [0:0]            action;
        logic [NODE_IDX_W-1:0] node_index;
        logic                  node_is_leaf;
        logic [SYM_W-1:0]      node_symbol;
        logic [NODE_IDX_W-1:0] node_left;
        logic [NODE_IDX_W-1:0] node_right;
        logic [BYTE_W-1:0]     data_byte;
    } in_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             symbol_valid;
        logic             last;
        logic             done_res;
    } out_item_t;

    typedef struct packed {
        logic                  is_leaf;
        logic [SYM_W-1:0]      symbol;
        logic [NODE_IDX_W-1:0] left;
        logic [NODE_IDX_W-1:0] right;
    } node_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH_CUR,
        ST_WALK,
        ST_FLUSH
    } state_t;

endpackage

// ===== sv/huffman_tree_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// Huffman tree stream decoder
// Loads a node table and emits symbols, walking one bit per cycle unless stalled.
// ----------------------------------------------------------------------------
// A node load is written as it is accepted. A stream byte is handled in steps:
// accepting it and fetching the root node, fetching the node where the previous
// byte left off, one read per bit through the single read port of the node
// memory, checking the final bit and handing over the closing result. The count
// byte goes straight to the closing result and ignored bytes are only accepted.
// A full result register stalls the walk only when a leaf is reached while a
// symbol is already pending and the earlier one has not been taken.
module huffman_tree_stream_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  htsd_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output htsd_pkg::out_item_t         m_data,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [htsd_pkg::CFG_W-1:0]  cfg_data
);

    htsd_pkg::node_t mem [htsd_pkg::NODE_COUNT];

    htsd_pkg::state_t state_reg, state_next;

    htsd_pkg::node_t                     rd_q_reg;
    logic                                rd_en;
    logic [htsd_pkg::NODE_IDX_W-1:0]     rd_addr;
    logic                                wr_en;

    htsd_pkg::node_t                     root_data_reg, root_data_next;
    logic [htsd_pkg::CFG_W-1:0]          total_bytes_reg, total_bytes_next;
    logic [htsd_pkg::NODE_IDX_W-1:0]     root_index_reg, root_index_next;
    logic [htsd_pkg::NODE_IDX_W-1:0]     current_node_reg, current_node_next;
    logic [htsd_pkg::CFG_W-1:0]          byte_pos_reg, byte_pos_next;
    logic [htsd_pkg::BITCNT_W-1:0]       final_bits_reg, final_bits_next;
    logic                                finished_reg, finished_next;

    logic [htsd_pkg::BYTE_W-1:0]         shift_reg, shift_next;
    logic [htsd_pkg::BITCNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [htsd_pkg::BITCNT_W-1:0]       nbits_reg, nbits_next;
    logic                                eval_reg, eval_next;
    logic                                is_final_reg, is_final_next;
    logic                                done_flag_reg, done_flag_next;
    logic                                pend_valid_reg, pend_valid_next;
    logic [htsd_pkg::SYM_W-1:0]          pend_sym_reg, pend_sym_next;

    logic                                m_valid_reg, m_valid_next;
    htsd_pkg::out_item_t                 m_data_reg, m_data_next;

    logic                                s_xfer;
    logic                                out_free;
    logic [htsd_pkg::CFG_W:0]            pos_p1;
    logic [htsd_pkg::CFG_W:0]            pos_p2;
    logic [htsd_pkg::CFG_W:0]            total_ext;
    logic                                leaf;
    htsd_pkg::node_t                     cur_node;
    logic [htsd_pkg::NODE_IDX_W-1:0]     child;
    logic                                issue;
    logic                                stall;

    assign s_ready   = (state_reg == htsd_pkg::ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign pos_p1    = {1'b0, byte_pos_reg} + (htsd_pkg::CFG_W + 1)'(1);
    assign pos_p2    = {1'b0, byte_pos_reg} + (htsd_pkg::CFG_W + 1)'(2);
    assign total_ext = {1'b0, total_bytes_reg};

    assign leaf      = eval_reg && rd_q_reg.is_leaf;
    assign cur_node  = leaf ? root_data_reg : rd_q_reg;
    assign child     = shift_reg[htsd_pkg::BYTE_W-1] ? cur_node.right : cur_node.left;
    assign issue     = (bit_cnt_reg != nbits_reg);
    assign stall     = leaf && pend_valid_reg && !out_free;

    assign wr_en     = s_xfer && (s_data.action == htsd_pkg::ACT_LOAD);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[s_data.node_index] <= '{is_leaf: s_data.node_is_leaf,
                                        symbol:  s_data.node_symbol,
                                        left:    s_data.node_left,
                                        right:   s_data.node_right};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= htsd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_bytes_reg  <= htsd_pkg::CFG_W'(2);
            root_index_reg   <= '0;
            current_node_reg <= '0;
            byte_pos_reg     <= '0;
            final_bits_reg   <= htsd_pkg::FULL_BITS;
            finished_reg     <= 1'b0;
            bit_cnt_reg      <= '0;
            nbits_reg        <= '0;
            eval_reg         <= 1'b0;
            is_final_reg     <= 1'b0;
            done_flag_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            total_bytes_reg  <= total_bytes_next;
            root_index_reg   <= root_index_next;
            current_node_reg <= current_node_next;
            byte_pos_reg     <= byte_pos_next;
            final_bits_reg   <= final_bits_next;
            finished_reg     <= finished_next;
            bit_cnt_reg      <= bit_cnt_next;
            nbits_reg        <= nbits_next;
            eval_reg         <= eval_next;
            is_final_reg     <= is_final_next;
            done_flag_reg    <= done_flag_next;
            pend_valid_reg   <= pend_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        root_data_reg <= root_data_next;
        shift_reg     <= shift_next;
        pend_sym_reg  <= pend_sym_next;
        m_data_reg    <= m_data_next;
    end

    always_comb begin
        state_next        = state_reg;
        rd_en             = 1'b0;
        rd_addr           = root_index_reg;
        root_data_next    = root_data_reg;
        total_bytes_next  = total_bytes_reg;
        root_index_next   = root_index_reg;
        current_node_next = current_node_reg;
        byte_pos_next     = byte_pos_reg;
        final_bits_next   = final_bits_reg;
        finished_next     = finished_reg;
        shift_next        = shift_reg;
        bit_cnt_next      = bit_cnt_reg;
        nbits_next        = nbits_reg;
        eval_next         = eval_reg;
        is_final_next     = is_final_reg;
        done_flag_next    = done_flag_reg;
        pend_valid_next   = pend_valid_reg;
        pend_sym_next     = pend_sym_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                htsd_pkg::CFG_TOTAL_BYTES: begin
                    total_bytes_next = cfg_data;
                end
                htsd_pkg::CFG_ROOT_INDEX: begin
                    root_index_next   = cfg_data[htsd_pkg::NODE_IDX_W-1:0];
                    current_node_next = cfg_data[htsd_pkg::NODE_IDX_W-1:0];
                end
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            htsd_pkg::ST_IDLE: begin
                if (s_xfer && (s_data.action == htsd_pkg::ACT_DECODE) && !finished_reg
                    && (byte_pos_reg < total_bytes_reg)) begin
                    if (pos_p2 == total_ext) begin
                        // count byte
                        pend_valid_next = 1'b0;
                        done_flag_next  = 1'b0;
                        state_next      = htsd_pkg::ST_FLUSH;
                        if (s_data.data_byte == htsd_pkg::CHAR_ZERO) begin
                            done_flag_next = 1'b1;
                        end else begin
                            byte_pos_next = pos_p1[htsd_pkg::CFG_W-1:0];
                            if ((s_data.data_byte >= htsd_pkg::CHAR_ONE)
                                && (s_data.data_byte <= htsd_pkg::CHAR_EIGHT)) begin
                                final_bits_next = htsd_pkg::BITCNT_W'(
                                    s_data.data_byte - htsd_pkg::CHAR_ZERO);
                            end else begin
                                final_bits_next = htsd_pkg::FULL_BITS;
                            end
                        end
                    end else begin
                        rd_en          = 1'b1;
                        rd_addr        = root_index_reg;
                        is_final_next  = (pos_p1 == total_ext);
                        nbits_next     = (pos_p1 == total_ext) ? final_bits_reg
                                                               : htsd_pkg::FULL_BITS;
                        shift_next     = s_data.data_byte;
                        bit_cnt_next   = '0;
                        eval_next      = 1'b0;
                        done_flag_next = 1'b0;
                        byte_pos_next  = pos_p1[htsd_pkg::CFG_W-1:0];
                        state_next     = htsd_pkg::ST_FETCH_CUR;
                    end
                end
            end

            htsd_pkg::ST_FETCH_CUR: begin
                root_data_next = rd_q_reg;
                rd_en          = 1'b1;
                rd_addr        = current_node_reg;
                state_next     = htsd_pkg::ST_WALK;
            end

            htsd_pkg::ST_WALK: begin
                if (!stall) begin
                    if (leaf) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = '{symbol: pend_sym_reg, symbol_valid: 1'b1,
                                             last: 1'b0, done_res: 1'b0};
                        end
                        pend_valid_next   = 1'b1;
                        pend_sym_next     = rd_q_reg.symbol;
                        current_node_next = root_index_reg;
                    end
                    if (issue) begin
                        rd_en             = 1'b1;
                        rd_addr           = child;
                        current_node_next = child;
                        shift_next        = {shift_reg[htsd_pkg::BYTE_W-2:0], 1'b0};
                        bit_cnt_next      = bit_cnt_reg + htsd_pkg::BITCNT_W'(1);
                        eval_next         = 1'b1;
                    end else begin
                        done_flag_next = is_final_reg && leaf;
                        state_next     = htsd_pkg::ST_FLUSH;
                    end
                end
            end

            htsd_pkg::ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = '{symbol:       pend_valid_reg ? pend_sym_reg : '0,
                                        symbol_valid: pend_valid_reg,
                                        last:         1'b1,
                                        done_res:     done_flag_reg};
                    finished_next   = finished_reg || done_flag_reg;
                    pend_valid_next = 1'b0;
                    state_next      = htsd_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = htsd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== dv/tb_huffman_tree_stream_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman tree stream decoder testbench
// Loads node tables, sets roots and stream lengths, and feeds stream bytes.
// Every result transfer is compared field by field against a tree walk model
// kept alongside, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_huffman_tree_stream_decoder;
    import htsd_pkg::*;

    localparam int                    CLK_HALF     = 5;
    localparam int                    WATCHDOG     = 3000;
    localparam int                    SETTLE       = 16;
    localparam int                    RANDOM_ITEMS = 80;
    localparam int                    MAX_REPORTS  = 200;
    localparam logic [CFG_W-1:0]      LEN_OPEN     = 32'hFFFF_FFFF;
    localparam logic [NODE_IDX_W-1:0] TOP_SLOT     = '1;
    localparam logic [NODE_IDX_W-1:0] BOTTOM_SLOT  = '0;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_item_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_item_t        m_data;
    logic             cfg_we    = 1'b0;
    logic [0:0]       cfg_index = CFG_TOTAL_BYTES;
    logic [CFG_W-1:0] cfg_data  = '0;

    node_t                 tree_mem [NODE_COUNT];
    bit                    node_loaded [NODE_COUNT];
    bit                    slot_taken [NODE_COUNT];
    int                    loaded_list [$];
    logic [NODE_IDX_W-1:0] walk_node   = '0;
    logic [NODE_IDX_W-1:0] root_sel    = '0;
    logic [CFG_W-1:0]      stream_pos  = '0;
    logic [CFG_W-1:0]      stream_len  = 32'd2;
    int                    tail_bits   = BYTE_W;
    bit                    stream_done = 1'b0;
    out_item_t             pending_symbols [$];

    int          errors      = 0;
    int          items_taken = 0;
    int          idle_cycles = 0;
    bit          no_idling   = 1'b0;
    int unsigned ready_hold  = 0;

    always #CLK_HALF aclk = ~aclk;

    huffman_tree_stream_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_idling) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[BYTE_W-1:0];
    endfunction

    function automatic in_item_t random_item(input logic [0:0] act);
        logic [63:0] r;
        in_item_t    it;
        r  = {$urandom, $urandom};
        it = r[$bits(in_item_t)-1:0];
        it.action = act;
        return it;
    endfunction

    function automatic logic [NODE_IDX_W-1:0] any_loaded(input logic [NODE_IDX_W-1:0] fallback);
        if (loaded_list.size() == 0) return fallback;
        return NODE_IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
    endfunction

    // Returns 1 when the item is taken up by the decoder rather than ignored.
    function automatic bit predict_symbols(input in_item_t it);
        out_item_t             res [BYTE_W];
        int                    count;
        int                    nbits;
        bit                    is_final;
        bit                    ended;
        logic [NODE_IDX_W-1:0] child;
        logic [CFG_W:0]        pos_ext;
        logic [CFG_W:0]        len_ext;
        count = 0;
        ended = 1'b0;
        if (it.action == ACT_LOAD) begin
            tree_mem[it.node_index] = '{is_leaf: it.node_is_leaf, symbol: it.node_symbol,
                                        left: it.node_left, right: it.node_right};
            if (!node_loaded[it.node_index]) begin
                node_loaded[it.node_index] = 1'b1;
                loaded_list = {loaded_list, int'(it.node_index)};
            end
            return 1'b1;
        end
        if (stream_done || stream_pos >= stream_len) return 1'b0;
        pos_ext = {1'b0, stream_pos};
        len_ext = {1'b0, stream_len};
        if (pos_ext + 2 == len_ext) begin
            res[0] = '0;
            res[0].last = 1'b1;
            if (it.data_byte == CHAR_ZERO) begin
                stream_done     = 1'b1;
                res[0].done_res = 1'b1;
            end else begin
                if (it.data_byte >= CHAR_ONE && it.data_byte <= CHAR_EIGHT)
                    tail_bits = int'(it.data_byte - CHAR_ZERO);
                else
                    tail_bits = BYTE_W;
                stream_pos = stream_pos + 1;
            end
            pending_symbols = {pending_symbols, res[0]};
            return 1'b1;
        end
        is_final = (pos_ext + 1 == len_ext);
        nbits    = is_final ? tail_bits : BYTE_W;
        for (int b = 0; b < nbits; b++) begin
            child = it.data_byte[BYTE_W-1-b] ? tree_mem[walk_node].right
                                             : tree_mem[walk_node].left;
            walk_node = child;
            ended     = 1'b0;
            if (tree_mem[child].is_leaf) begin
                res[count] = '{symbol: tree_mem[child].symbol, symbol_valid: 1'b1,
                               last: 1'b0, done_res: 1'b0};
                count++;
                walk_node = root_sel;
                ended     = 1'b1;
            end
        end
        stream_pos = stream_pos + 1;
        if (count == 0) begin
            res[0] = '0;
            count  = 1;
        end
        res[count-1].last = 1'b1;
        if (is_final && ended) begin
            stream_done = 1'b1;
            res[count-1].done_res = 1'b1;
        end
        for (int k = 0; k < count; k++) pending_symbols = {pending_symbols, res[k]};
        return 1'b1;
    endfunction

    function automatic bit walk_lands_on_leaf(input logic [BYTE_W-1:0] v, input int nbits);
        logic [NODE_IDX_W-1:0] at;
        bit                    ended;
        at    = walk_node;
        ended = 1'b0;
        for (int i = 0; i < nbits; i++) begin
            at    = v[BYTE_W-1-i] ? tree_mem[at].right : tree_mem[at].left;
            ended = tree_mem[at].is_leaf;
            if (ended) at = root_sel;
        end
        return ended;
    endfunction

    function automatic int find_final_byte(input int nbits, input bit on_leaf);
        int                start;
        logic [BYTE_W-1:0] v;
        start = $urandom_range(0, 255);
        for (int k = 0; k < 256; k++) begin
            v = BYTE_W'(start + k);
            if (walk_lands_on_leaf(v, nbits) == on_leaf) return int'(v);
        end
        return -1;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_symbol(input out_item_t got);
        out_item_t want;
        if (pending_symbols.size() == 0) begin
            report_mismatch($sformatf("transfer with nothing expected: %p", got));
            return;
        end
        want = pending_symbols.pop_front();
        if (got.symbol !== want.symbol)
            report_mismatch($sformatf("symbol %h, want %h", got.symbol, want.symbol));
        if (got.symbol_valid !== want.symbol_valid)
            report_mismatch($sformatf("symbol_valid %b, want %b",
                                      got.symbol_valid, want.symbol_valid));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        if (got.done_res !== want.done_res)
            report_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_symbol(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (no_idling) begin
            m_ready    <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= ($urandom_range(0, 3) != 0);
            ready_hold <= pick_gap();
        end
    end

    task automatic send_item(input in_item_t it);
        int unsigned gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (predict_symbols(it)) items_taken++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] v);
        in_item_t it;
        it = random_item(ACT_DECODE);
        it.data_byte = v;
        send_item(it);
    endtask

    task automatic load_node(input logic [NODE_IDX_W-1:0] idx, input logic leaf,
                             input logic [SYM_W-1:0] sym,
                             input logic [NODE_IDX_W-1:0] left,
                             input logic [NODE_IDX_W-1:0] right);
        in_item_t it;
        it = random_item(ACT_LOAD);
        it.node_index   = idx;
        it.node_is_leaf = leaf;
        it.node_symbol  = sym;
        it.node_left    = left;
        it.node_right   = right;
        send_item(it);
    endtask

    // Hold until every expected transfer is in and the walk has settled.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(input logic [0:0] idx, input logic [CFG_W-1:0] value);
        drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_TOTAL_BYTES) begin
            stream_len = value;
        end else begin
            root_sel  = value[NODE_IDX_W-1:0];
            walk_node = root_sel;
        end
    endtask

    task automatic set_root(input logic [NODE_IDX_W-1:0] idx);
        logic [31:0] r;
        r = $urandom;
        write_register(CFG_ROOT_INDEX, {r[CFG_W-1:NODE_IDX_W], idx});
    endtask

    function automatic int claim_slot();
        int slot;
        do slot = $urandom_range(0, NODE_COUNT - 1); while (slot_taken[slot]);
        slot_taken[slot] = 1'b1;
        return slot;
    endfunction

    // Build bottom up so that every child is in the table before its parent.
    task automatic build_tree(input int leaf_count, input bit chain,
                              output logic [NODE_IDX_W-1:0] top);
        int                    pool [$];
        int                    a;
        int                    b;
        int                    i;
        logic [NODE_IDX_W-1:0] slot;
        foreach (slot_taken[k]) slot_taken[k] = 1'b0;
        for (int n = 0; n < leaf_count; n++) begin
            slot = NODE_IDX_W'(claim_slot());
            load_node(slot, 1'b1, rand_byte(), any_loaded(slot), any_loaded(slot));
            pool = {pool, int'(slot)};
        end
        while (pool.size() > 1) begin
            if (chain) begin
                a = pool.pop_back();
                b = pool.pop_back();
            end else begin
                i = $urandom_range(0, pool.size() - 1);
                a = pool[i];
                pool.delete(i);
                i = $urandom_range(0, pool.size() - 1);
                b = pool[i];
                pool.delete(i);
            end
            slot = NODE_IDX_W'(claim_slot());
            if ($urandom_range(0, 1))
                load_node(slot, 1'b0, rand_byte(), NODE_IDX_W'(a), NODE_IDX_W'(b));
            else
                load_node(slot, 1'b0, rand_byte(), NODE_IDX_W'(b), NODE_IDX_W'(a));
            pool = {pool, int'(slot)};
        end
        top = NODE_IDX_W'(pool[0]);
    endtask

    // Count byte, then a final byte that either stops mid-path or lands on a leaf.
    task automatic count_sequence(input logic [BYTE_W-1:0] count_byte, input bit end_on_leaf);
        int fin;
        set_root(root_sel);
        write_register(CFG_TOTAL_BYTES, stream_pos + 2);
        send_byte(count_byte);
        if (!stream_done) begin
            fin = find_final_byte(tail_bits, end_on_leaf);
            if (fin >= 0) begin
                send_byte(fin[BYTE_W-1:0]);
                send_byte(rand_byte());
            end
        end
        if (!stream_done) write_register(CFG_TOTAL_BYTES, LEN_OPEN);
    endtask

    task automatic test_short_stream();
        logic [NODE_IDX_W-1:0] top;
        int                    fin;
        build_tree(3, 1'b1, top);
        set_root(top);
        write_register(CFG_TOTAL_BYTES, 32'd1);
        fin = find_final_byte(tail_bits, 1'b0);
        if (fin >= 0) send_byte(fin[BYTE_W-1:0]);
        send_byte(rand_byte());
        write_register(CFG_TOTAL_BYTES, 32'd0);
        send_byte(rand_byte());
    endtask

    task automatic test_count_byte();
        count_sequence(CHAR_ONE, 1'b0);
        count_sequence(CHAR_EIGHT, 1'b0);
        count_sequence(CHAR_EIGHT + 8'd1, 1'b0);
    endtask

    task automatic test_full_bytes();
        write_register(CFG_TOTAL_BYTES, LEN_OPEN);
        no_idling = 1'b1;
        load_node(TOP_SLOT, 1'b1, 8'hFF, TOP_SLOT, TOP_SLOT);
        load_node(BOTTOM_SLOT, 1'b0, 8'h00, TOP_SLOT, TOP_SLOT);
        set_root(BOTTOM_SLOT);
        send_byte(8'h00);
        send_byte(8'hFF);
        no_idling = 1'b0;
        load_node(TOP_SLOT, 1'b1, 8'h00, TOP_SLOT, TOP_SLOT);
        send_byte(8'h5A);
        // a root marked as leaf still has its children followed
        load_node(BOTTOM_SLOT, 1'b1, 8'h80, TOP_SLOT, BOTTOM_SLOT);
        send_byte(8'hC3);
        set_root(TOP_SLOT);
        send_byte(rand_byte());
    endtask

    task automatic test_random_traffic();
        int                    start;
        int                    choice;
        logic [NODE_IDX_W-1:0] top;
        logic [NODE_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]     cnt;
        start = items_taken;
        while (items_taken - start < RANDOM_ITEMS) begin
            no_idling = ($urandom_range(0, 5) == 0);
            choice    = $urandom_range(0, 9);
            if (choice < 2) begin
                build_tree(int'($urandom_range(2, 10)), 1'($urandom_range(0, 1)), top);
                set_root(top);
            end else if (choice < 6) begin
                repeat ($urandom_range(1, 8)) send_byte(rand_byte());
            end else if (choice < 8) begin
                if ($urandom_range(0, 9) < 7) cnt = BYTE_W'(CHAR_ZERO + $urandom_range(1, 8));
                else cnt = rand_byte();
                if (cnt == CHAR_ZERO) cnt = CHAR_EIGHT + 8'd1;
                count_sequence(cnt, 1'b0);
            end else if (choice == 8) begin
                repeat ($urandom_range(1, 3)) begin
                    idx = NODE_IDX_W'($urandom_range(0, NODE_COUNT - 1));
                    load_node(idx, 1'($urandom_range(0, 1)), rand_byte(),
                              any_loaded(idx), any_loaded(idx));
                end
            end else begin
                set_root(any_loaded(root_sel));
            end
        end
        no_idling = 1'b0;
    endtask

    task automatic test_stream_end();
        logic [NODE_IDX_W-1:0] top;
        int                    digit;
        digit = 0;
        build_tree(int'($urandom_range(3, 6)), 1'b1, top);
        set_root(top);
        if ($urandom_range(0, 1)) begin
            for (int c = 1; c <= BYTE_W && digit == 0; c++)
                if (find_final_byte(c, 1'b1) >= 0) digit = c;
        end
        if (digit != 0) begin
            count_sequence(BYTE_W'(CHAR_ZERO + digit), 1'b1);
        end else begin
            write_register(CFG_TOTAL_BYTES, stream_pos + 2);
            send_byte(CHAR_ZERO);
        end
        repeat (3) send_byte(rand_byte());
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        test_short_stream();
        test_count_byte();
        test_full_bytes();
        test_random_traffic();
        test_stream_end();
        drain();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/htsd_pkg.sv
sv/huffman_tree_stream_decoder.sv
dv/tb_huffman_tree_stream_decoder.sv
